>>> hw/rtl/sob_pkg.sv
// Shared types and constants for the Sobel gradient magnitude block.
// Used by sob_isqrt and sobel_edge_magnitude_top; depends on nothing else.
package sob_pkg;

   localparam int PIX_W      = 8;     // grey level width
   localparam int GRAD_W     = 11;    // signed Sobel sum width
   localparam int MAG_W      = 11;    // magnitude width
   localparam int ROW_W      = 12;    // row counter and out_row width
   localparam int COL_W      = 10;    // column counter and out_col width
   localparam int LW_W       = 11;    // line_width register width
   localparam int RAD_W      = 21;    // gx^2 + gy^2 always fits in 21 bits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_WIDTH  = 3;
   localparam int MAX_MAGNITUDE = 1442;

   localparam logic [LW_W-1:0] LINE_WIDTH_RESET = LW_W'(640);

   // Packed result beat: magnitude, grad_x, grad_y, out_row, out_col, padding.
   localparam int RSP_FIELDS_W = MAG_W + 2 * GRAD_W + ROW_W + COL_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Status returned by the square-root unit.
   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] root;
   } sqrt_status_type;

endpackage

>>> hw/rtl/sobel_edge_magnitude_top.sv
// Top level of the 3x3 Sobel gradient magnitude block: line store, window,
// counters and output register. Depends on sob_pkg and sob_isqrt.
//
// Usage: pixels arrive in raster order on the req_ stream, one per beat, with
// req_tuser set on the first pixel of a frame. The csr_ port sets the row
// width in use; write it only while the block is idle. For every pixel whose
// 3x3 window is complete (row at least 2, column at least 2) one result beat
// leaves on the rsp_ stream with the magnitude, both gradients, the window's
// centre row and left column.
// Timing: the block works on one pixel at a time. A pixel that gives no result
// passes through the read state and back to idle. A pixel that gives a result
// also waits on the 11-step square-root loop, which retires two radicand bits
// per cycle; the line store is read at accept, ahead of the read state.
// A finished result sits in the output register, so the next pixel is taken
// while the receiver stalls; only a second result waits for the first to go.
// Reset clears the counters, the window and the output valid and sets the
// width to 640. The line store is not cleared: its entries are defined once
// the row above has been written.
module sobel_edge_magnitude_top (
   input  logic                             clock,
   input  logic                             reset,
   // Configuration: line_width.
   input  logic                             csr_we,
   input  logic [sob_pkg::LW_W-1:0]         csr_wdata,
   // Pixel stream.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sob_pkg::PIX_W-1:0]        req_tdata,   // [7:0] pixel
   input  logic                             req_tuser,   // [0] frame_start
   // Result stream.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [10:0] magnitude, [21:11] grad_x, [32:22] grad_y, [44:33] out_row,
   // [54:45] out_col, [55] zero
   output logic [sob_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int PIX_W  = sob_pkg::PIX_W;
   localparam int GRAD_W = sob_pkg::GRAD_W;
   localparam int COL_W  = sob_pkg::COL_W;
   localparam int ROW_W  = sob_pkg::ROW_W;
   localparam int LW_W   = sob_pkg::LW_W;
   localparam int PAD_W  = sob_pkg::RSP_TDATA_W - sob_pkg::RSP_FIELDS_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_GO   = 5'b00100,
      ST_ROOT = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [LW_W-1:0]  line_width_ff, line_width_in;
   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             emit_ff, emit_in;
   logic [PIX_W-1:0] cells_ff [6];
   logic [PIX_W-1:0] cells_in [6];
   logic signed [GRAD_W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [sob_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // Line store: each entry holds {row two up, row one up} for one column.
   logic [2*PIX_W-1:0] line_mem [sob_pkg::MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;
   logic               mem_we;
   logic [2*PIX_W-1:0] mem_wdata;

   logic             req_fire, out_load, sq_start;
   logic [LW_W-1:0]  width;
   logic [COL_W-1:0] col_base, col_cur;
   logic [ROW_W-1:0] row_base;
   logic [LW_W-1:0]  col_next;
   logic [PIX_W-1:0] top_new, mid_new;
   logic signed [GRAD_W-1:0] e_c0, e_c1, e_c2, e_c3, e_c5, e_t, e_m, e_b;
   sob_pkg::sqrt_status_type sq_status;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_load   = !rsp_tvalid_ff || rsp_tready;

   // Width in force, held to the supported range.
   always_comb begin
      priority if (line_width_ff < LW_W'(sob_pkg::MIN_WIDTH)) begin
         width = LW_W'(sob_pkg::MIN_WIDTH);
      end else if (line_width_ff > LW_W'(sob_pkg::MAX_WIDTH)) begin
         width = LW_W'(sob_pkg::MAX_WIDTH);
      end else begin
         width = line_width_ff;
      end
   end

   // Column and row of the incoming pixel; a frame start clears both first,
   // and a column left over from a wider setting wraps to zero.
   always_comb begin
      col_base = req_tuser ? '0 : col_count_ff;
      row_base = req_tuser ? '0 : row_count_ff;
      col_cur  = ({1'b0, col_base} >= width) ? '0 : col_base;
      col_next = {1'b0, col_cur} + LW_W'(1);
   end

   // New window column from the line store and the pending pixel.
   assign top_new = rd_data_ff[2*PIX_W-1:PIX_W];
   assign mid_new = rd_data_ff[PIX_W-1:0];

   assign e_c0 = {{(GRAD_W - PIX_W){1'b0}}, cells_ff[0]};
   assign e_c1 = {{(GRAD_W - PIX_W){1'b0}}, cells_ff[1]};
   assign e_c2 = {{(GRAD_W - PIX_W){1'b0}}, cells_ff[2]};
   assign e_c3 = {{(GRAD_W - PIX_W){1'b0}}, cells_ff[3]};
   assign e_c5 = {{(GRAD_W - PIX_W){1'b0}}, cells_ff[5]};
   assign e_t  = {{(GRAD_W - PIX_W){1'b0}}, top_new};
   assign e_m  = {{(GRAD_W - PIX_W){1'b0}}, mid_new};
   assign e_b  = {{(GRAD_W - PIX_W){1'b0}}, pix_ff};

   assign mem_wdata = {mid_new, pix_ff};

   always_comb begin
      state_in      = state_ff;
      line_width_in = csr_we ? csr_wdata : line_width_ff;
      col_count_in  = col_count_ff;
      row_count_in  = row_count_ff;
      pix_in        = pix_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      emit_in       = emit_ff;
      cells_in      = cells_ff;
      gx_in         = gx_ff;
      gy_in         = gy_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      mem_we        = 1'b0;
      sq_start      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pix_in  = req_tdata;
               col_in  = col_cur;
               row_in  = row_base;
               emit_in = (row_base >= ROW_W'(2)) && (col_cur >= COL_W'(2));
               if (col_next >= width) begin
                  col_count_in = '0;
                  if (row_base != ROW_W'(sob_pkg::MAX_HEIGHT - 1)) begin
                     row_count_in = row_base + ROW_W'(1);
                  end else begin
                     row_count_in = row_base;
                  end
               end else begin
                  col_count_in = col_next[COL_W-1:0];
                  row_count_in = row_base;
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // Rotate the line store entry and slide the window one column.
            mem_we = 1'b1;
            gx_in  = e_t - e_c0 + ((e_m - e_c1) <<< 1) + e_b - e_c2;
            gy_in  = e_c2 - e_c0 + ((e_c5 - e_c3) <<< 1) + e_b - e_t;
            cells_in[0] = cells_ff[3];
            cells_in[1] = cells_ff[4];
            cells_in[2] = cells_ff[5];
            cells_in[3] = top_new;
            cells_in[4] = mid_new;
            cells_in[5] = pix_ff;
            if (emit_ff) begin
               out_row_in = row_ff - ROW_W'(1);
               out_col_in = col_ff - COL_W'(2);
               state_in   = ST_GO;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_GO: begin
            sq_start = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sq_status.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {{PAD_W{1'b0}}, out_col_ff, out_row_ff, gy_ff, gx_ff,
                                sq_status.root};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         line_width_ff <= sob_pkg::LINE_WIDTH_RESET;
         col_count_ff  <= '0;
         row_count_ff  <= '0;
         emit_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            cells_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         line_width_ff <= line_width_in;
         col_count_ff  <= col_count_in;
         row_count_ff  <= row_count_in;
         emit_ff       <= emit_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         cells_ff      <= cells_in;
      end
      pix_ff       <= pix_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      gx_ff        <= gx_in;
      gy_ff        <= gy_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // Line store: read at accept, written back in the read state.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= line_mem[col_cur];
      end
      if (mem_we) begin
         line_mem[col_ff] <= mem_wdata;
      end
   end

   sob_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start),
      .grad_x (gx_ff),
      .grad_y (gy_ff),
      .status (sq_status)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // An accepted pixel always goes to the line store read next.
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_READ)
      else $error("accepted pixel did not enter the read state");

   // The root unit only finishes while the controller waits for it.
   a_root_done_waited: assert property (@(posedge clock) disable iff (reset)
      sq_status.done |-> state_ff == ST_ROOT)
      else $error("square root finished outside the wait state");

   // A result load raises the output valid and frees the input side.
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_load) |=> (rsp_tvalid_ff && state_ff == ST_IDLE))
      else $error("result load did not reach the output register");

   // The magnitude can never exceed the largest possible gradient length.
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |->
         rsp_tdata_ff[sob_pkg::MAG_W-1:0] <= sob_pkg::MAG_W'(sob_pkg::MAX_MAGNITUDE))
      else $error("magnitude out of range");

endmodule

>>> hw/rtl/sob_isqrt.sv
// Squares the two gradients, adds them and takes the integer square root,
// two radicand bits per cycle. Depends on sob_pkg.
module sob_isqrt (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [sob_pkg::GRAD_W-1:0]    grad_x,
   input  logic signed [sob_pkg::GRAD_W-1:0]    grad_y,
   output sob_pkg::sqrt_status_type             status
);

   typedef enum logic [2:0] {
      SQ_IDLE = 3'b001,
      SQ_SUM  = 3'b010,
      SQ_STEP = 3'b100
   } sq_state_type;

   localparam int RAD_W = sob_pkg::RAD_W;
   localparam logic [RAD_W-1:0] BIT_INIT = {1'b1, {(RAD_W - 1){1'b0}}};

   sq_state_type state_ff, state_in;
   logic [RAD_W-2:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [RAD_W-1:0] rad_ff, rad_in, root_ff, root_in, bit_ff, bit_in;
   logic             done_ff, done_in;

   logic signed [2*sob_pkg::GRAD_W-1:0] prod_x, prod_y;
   logic [RAD_W:0] trial;

   assign prod_x = grad_x * grad_x;
   assign prod_y = grad_y * grad_y;
   assign trial  = {1'b0, root_ff} + {1'b0, bit_ff};

   always_comb begin
      state_in = state_ff;
      sqx_in   = sqx_ff;
      sqy_in   = sqy_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               sqx_in   = prod_x[RAD_W-2:0];
               sqy_in   = prod_y[RAD_W-2:0];
               state_in = SQ_SUM;
            end
         end
         SQ_SUM: begin
            rad_in   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
            root_in  = '0;
            bit_in   = BIT_INIT;
            state_in = SQ_STEP;
         end
         SQ_STEP: begin
            if ({1'b0, rad_ff} >= trial) begin
               rad_in  = rad_ff - trial[RAD_W-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               done_in  = 1'b1;
               state_in = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign status.done = done_ff;
   assign status.root = root_ff[sob_pkg::MAG_W-1:0];

endmodule

>>> dv/tb_sobel_edge_magnitude_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for sobel_edge_magnitude_top: raster pixel streams in,
// Sobel gradient and magnitude beats checked against an in-bench predictor.
// Depends on sob_pkg and the block's RTL.
module tb_sobel_edge_magnitude_top;
   import sob_pkg::*;

   // Flow-control modes for the two streams.
   typedef enum {
      FLOW_FREE,
      FLOW_SENDER_GAPS,
      FLOW_RECEIVER_STALLS,
      FLOW_BOTH
   } flow_mode_e;

   // One expected result beat, in the block's field widths.
   typedef struct {
      logic [MAG_W-1:0]  magnitude;
      logic [GRAD_W-1:0] grad_x;
      logic [GRAD_W-1:0] grad_y;
      logic [ROW_W-1:0]  out_row;
      logic [COL_W-1:0]  out_col;
   } gradient_beat_t;

   // The block waits this many idle cycles before a register write or the end.
   localparam int SETTLE_CYCLES = 24;
   localparam int MAX_PRINTED   = 100;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [LW_W-1:0]         csr_wdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [PIX_W-1:0]        req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;

   flow_mode_e traffic_mode = FLOW_FREE;

   // Predictor state: its own copy of the line stores, the window and counters.
   logic [PIX_W-1:0] row_one_above [0:MAX_WIDTH-1];
   logic [PIX_W-1:0] row_two_above [0:MAX_WIDTH-1];
   int unsigned      window_history [0:5];   // older two window columns
   int unsigned      column_pos = 0;
   int unsigned      row_pos    = 0;
   logic [LW_W-1:0]  line_width_shadow = LINE_WIDTH_RESET;

   gradient_beat_t pending_gradients [$];

   int pixels_sent    = 0;
   int beats_checked  = 0;
   int mismatch_count = 0;

   sobel_edge_magnitude_top uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] pixel
      .req_tuser  (req_tuser),    // [0] frame_start
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // [10:0] magnitude, [21:11] grad_x, [32:22] grad_y, [44:33] out_row,
      // [54:45] out_col, [55] zero
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Every mismatch goes through here. Printing stops after a while so that a
   // badly broken block does not flood the log, but the count keeps going.
   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
      end
   endtask

   // The width the block actually uses: register values outside the legal
   // range are pinned to the nearest end.
   function automatic int unsigned active_line_width();
      if (line_width_shadow < MIN_WIDTH) begin
         return MIN_WIDTH;
      end
      if (line_width_shadow > MAX_WIDTH) begin
         return MAX_WIDTH;
      end
      return line_width_shadow;
   endfunction

   // Floor of the square root, one result bit at a time from the top.
   function automatic int unsigned floor_sqrt(input int unsigned radicand);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (trial * trial <= radicand) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Advances the predicted window by one accepted pixel. When the 3x3 window
   // is complete, the expected beat is queued.
   task automatic advance_sobel_window(input logic [PIX_W-1:0] pix, input logic frame_start);
      int unsigned    width;
      int unsigned    col;
      int unsigned    win [0:2][0:2];   // [row top to bottom][column left to right]
      int             gx;
      int             gy;
      gradient_beat_t beat;
      width = active_line_width();
      // A frame start clears the counts before the pixel is placed.
      if (frame_start) begin
         column_pos = 0;
         row_pos    = 0;
      end
      // A width that shrank under a running row wraps the column at once.
      if (column_pos >= width) begin
         column_pos = 0;
      end
      col = column_pos;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = window_history[i];
         win[i][1] = window_history[3 + i];
      end
      win[0][2] = row_two_above[col];
      win[1][2] = row_one_above[col];
      win[2][2] = pix;
      row_two_above[col] = row_one_above[col];
      row_one_above[col] = pix;
      if (row_pos >= 2 && col >= 2) begin
         gx = int'(win[0][2] + 2 * win[1][2] + win[2][2])
            - int'(win[0][0] + 2 * win[1][0] + win[2][0]);
         gy = int'(win[2][0] + 2 * win[2][1] + win[2][2])
            - int'(win[0][0] + 2 * win[0][1] + win[0][2]);
         beat.magnitude = MAG_W'(floor_sqrt(gx * gx + gy * gy));
         beat.grad_x    = GRAD_W'(gx);
         beat.grad_y    = GRAD_W'(gy);
         beat.out_row   = ROW_W'(row_pos - 1);
         beat.out_col   = COL_W'(col - 2);
         pending_gradients.push_back(beat);
      end
      for (int i = 0; i < 3; i++) begin
         window_history[i]     = win[i][1];
         window_history[3 + i] = win[i][2];
      end
      column_pos = col + 1;
      if (column_pos >= width) begin
         column_pos = 0;
         // The row count sticks at its top value on very tall frames.
         if (row_pos < MAX_HEIGHT - 1) begin
            row_pos++;
         end
      end
   endtask

   // Random grey level, leaning on black and white to reach the gradient ends.
   function automatic logic [PIX_W-1:0] random_pixel();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return '0;
      end
      if (pick == 1) begin
         return '1;
      end
      return PIX_W'($urandom_range(0, 255));
   endfunction

   // Drives one pixel beat and returns at the edge where it is accepted. The
   // valid stays high afterwards; a gap or a drain lowers it.
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic frame_start);
      while ((traffic_mode == FLOW_SENDER_GAPS && $urandom_range(0, 99) < 77) ||
             (traffic_mode == FLOW_BOTH && $urandom_range(0, 99) < 6)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= frame_start;
      do @(posedge clock); while (!req_tready);
      advance_sobel_window(pix, frame_start);
      pixels_sent++;
   endtask

   // A run of random pixels; the first one may open a new frame.
   task automatic send_stream(input int count, input bit restart);
      for (int i = 0; i < count; i++) begin
         send_pixel(random_pixel(), restart && i == 0);
      end
   endtask

   // Holds the sender back until every expected beat has come, then lets the
   // block finish any pixel that gives no result.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_gradients.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes only happen once the block has gone quiet.
   task automatic write_line_width(input logic [LW_W-1:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      line_width_shadow = value;
   endtask

   // Result side: random back-pressure and the field-by-field comparison
   // against the oldest queued expectation.
   always @(posedge clock) begin
      gradient_beat_t got;
      gradient_beat_t want;
      case (traffic_mode)
         FLOW_RECEIVER_STALLS: begin
            rsp_tready <= ($urandom_range(0, 99) >= 77);
         end
         FLOW_BOTH: begin
            rsp_tready <= ($urandom_range(0, 99) >= 6);
         end
         default: begin
            rsp_tready <= 1'b1;
         end
      endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.magnitude = rsp_tdata[MAG_W-1:0];
         got.grad_x    = rsp_tdata[MAG_W +: GRAD_W];
         got.grad_y    = rsp_tdata[MAG_W + GRAD_W +: GRAD_W];
         got.out_row   = rsp_tdata[MAG_W + 2 * GRAD_W +: ROW_W];
         got.out_col   = rsp_tdata[MAG_W + 2 * GRAD_W + ROW_W +: COL_W];
         if (pending_gradients.size() == 0) begin
            report_mismatch("result beat with no pixel behind it", got.magnitude, 0);
         end else begin
            want = pending_gradients.pop_front();
            beats_checked++;
            if (got.magnitude !== want.magnitude) begin
               report_mismatch("magnitude", got.magnitude, want.magnitude);
            end
            if (got.grad_x !== want.grad_x) begin
               report_mismatch("grad_x", $signed(got.grad_x), $signed(want.grad_x));
            end
            if (got.grad_y !== want.grad_y) begin
               report_mismatch("grad_y", $signed(got.grad_y), $signed(want.grad_y));
            end
            if (got.out_row !== want.out_row) begin
               report_mismatch("out_row", got.out_row, want.out_row);
            end
            if (got.out_col !== want.out_col) begin
               report_mismatch("out_col", got.out_col, want.out_col);
            end
         end
      end
   end

   // No register write here: the width must come up at its reset value of 640.
   // Two full rows and a few pixels of the third prove where the row wraps.
   task automatic test_reset_width();
      traffic_mode = FLOW_FREE;
      send_stream(2 * active_line_width() + 8, 1'b1);
   endtask

   // Three-pixel rows make each new row a complete window, so the rows below
   // are chosen to drive grad_y to its positive end and grad_x to its negative end.
   // A register value of zero is below the legal range and acts as three.
   task automatic test_gradient_extremes();
      int unsigned pattern [0:7][0:2] = '{
         '{  0,   0,   0}, '{  0,   0,   0}, '{255, 255, 255},
         '{255,   0,   0}, '{255,   0,   0}, '{255,   0,   0},
         '{  0,   0, 255}, '{  0, 255, 255}
      };
      traffic_mode = FLOW_FREE;
      write_line_width('0);
      for (int r = 0; r < 8; r++) begin
         for (int c = 0; c < 3; c++) begin
            send_pixel(PIX_W'(pattern[r][c]), r == 0 && c == 0);
         end
      end
   endtask

   // Frame starts landing mid-row and right on a row boundary. The window and
   // line stores survive, but no result may appear until the window refills.
   task automatic test_frame_restart();
      traffic_mode = FLOW_FREE;
      write_line_width(LW_W'(5));
      send_stream(2 * 5 + 4, 1'b1);
      send_stream(2 * 5 + 3, 1'b1);
      send_stream(3 * 5, 1'b1);
      send_stream(2 * 5 + 3, 1'b1);
   endtask

   // The largest register value acts as the widest row. Three full rows reach
   // the last output column and leave every line store entry written.
   task automatic test_wide_rows();
      traffic_mode = FLOW_FREE;
      write_line_width('1);
      send_stream(3 * active_line_width(), 1'b1);
   endtask

   // Width changes inside a running frame: shrinking below the current column
   // wraps the column without a new row; growing reuses entries that the wide
   // frame already filled.
   task automatic test_width_change_mid_frame();
      traffic_mode = FLOW_FREE;
      write_line_width(LW_W'(8));
      send_stream(2 * 8 + 6, 1'b1);
      write_line_width(LW_W'(4));
      send_stream(10, 1'b0);
      write_line_width(LW_W'(12));
      send_stream(30, 1'b0);
   endtask

   // A frame taller than the row counter: the centre row must stop at its top.
   task automatic test_row_saturation();
      traffic_mode = FLOW_FREE;
      write_line_width(LW_W'(MIN_WIDTH));
      send_stream(MIN_WIDTH * (MAX_HEIGHT + 4), 1'b1);
   endtask

   // Mostly well-formed frames of random small widths with random content,
   // sprinkled with stray frame starts and an occasional full drain, under
   // each flow-control mode in turn.
   task automatic test_random_traffic();
      logic [LW_W-1:0] width;
      bit              frame_start;
      for (int m = 0; m < 4; m++) begin
         traffic_mode = flow_mode_e'(m);
         for (int phase = 0; phase < 2; phase++) begin
            if ($urandom_range(0, 99) < 15) begin
               width = LW_W'($urandom_range(0, MIN_WIDTH - 1));
            end else begin
               width = LW_W'($urandom_range(MIN_WIDTH, 20));
            end
            write_line_width(width);
            for (int i = 0; i < 75; i++) begin
               frame_start = (i == 0) || ($urandom_range(0, 99) < 3);
               if ($urandom_range(0, 199) == 0) begin
                  drain_results();
               end
               send_pixel(random_pixel(), frame_start);
            end
         end
      end
      traffic_mode = FLOW_FREE;
   endtask

   initial begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         row_one_above[i] = '0;
         row_two_above[i] = '0;
      end
      for (int i = 0; i < 6; i++) begin
         window_history[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_width();
      test_gradient_extremes();
      test_frame_restart();
      test_wide_rows();
      test_width_change_mid_frame();
      test_row_saturation();
      test_random_traffic();

      // Let the last results out, then give the block time to show any extra.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_gradients.size() != 0) begin
         report_mismatch("expected beats never delivered", 0, pending_gradients.size());
      end

      $display("Run covered %0d pixels and %0d result beats over widths 3 to 1024,",
               pixels_sent, beats_checked);
      $display("frame restarts, mid-frame width changes, row saturation and stalls.");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: well above the slowest correct run, so only a hang trips it.
   initial begin
      #8_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
